[rtl/core/pirmp_pkg.sv]
// Shared types and constants for the PI controller with setpoint ramp.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package pirmp_pkg;

    // Full-scale output magnitude in integer units; the reset clamps are this
    // value scaled by the fraction bits.
    localparam int FULL_SCALE = 900;

    // Widths of the datapath.
    localparam int DATA_W  = 32;
    localparam int ACCEL_W = 31;
    localparam int ERR_W   = DATA_W + 1;
    localparam int PRODP_W = DATA_W + ERR_W;
    localparam int PRODI_W = DATA_W + DATA_W;
    localparam int CFG_IDX_W = 3;

    // Item operation codes.
    typedef enum logic {
        OP_STEP = 1'b0,
        OP_INIT = 1'b1
    } op_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_P_GAIN      = 3'd0,
        CFG_I_GAIN      = 3'd1,
        CFG_OUT_MIN     = 3'd2,
        CFG_OUT_MAX     = 3'd3,
        CFG_ACCEL_LIMIT = 3'd4
    } cfg_idx_t;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic signed [DATA_W-1:0] p_gain;
        logic signed [DATA_W-1:0] i_gain;
        logic signed [DATA_W-1:0] out_min;
        logic signed [DATA_W-1:0] out_max;
        logic [ACCEL_W-1:0]       accel_limit;
    } cfg_t;

    // Payload leaving the state update stage.
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [DATA_W-1:0] integ;
    } stage1_t;

    // Payload leaving the multiplier stage.
    typedef struct packed {
        logic signed [PRODP_W-1:0] prod_p;
        logic signed [PRODI_W-1:0] prod_i;
    } stage2_t;

endpackage

[rtl/core/pirmp_cfg_regs.sv]
// Configuration register file for the PI controller.
// Depends on pirmp_pkg for the register index codes and the cfg_t struct.
`timescale 1ns / 1ps

module pirmp_cfg_regs #(
    parameter int FRAC_BITS = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pirmp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pirmp_pkg::DATA_W-1:0]      cfg_data,
    output pirmp_pkg::cfg_t                   cfg
);
    import pirmp_pkg::*;

    localparam logic signed [DATA_W-1:0] LIMIT_RST = DATA_W'(FULL_SCALE << FRAC_BITS);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the write index; unknown indexes leave the registers unchanged.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_P_GAIN:      cfg_next.p_gain      = cfg_data;
                CFG_I_GAIN:      cfg_next.i_gain      = cfg_data;
                CFG_OUT_MIN:     cfg_next.out_min     = cfg_data;
                CFG_OUT_MAX:     cfg_next.out_max     = cfg_data;
                CFG_ACCEL_LIMIT: cfg_next.accel_limit = cfg_data[ACCEL_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.p_gain      <= '0;
            cfg_reg.i_gain      <= '0;
            cfg_reg.out_min     <= -LIMIT_RST;
            cfg_reg.out_max     <= LIMIT_RST;
            cfg_reg.accel_limit <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/core/pirmp_state.sv]
// Input register and loop state update (ramped target and integral).
// Depends on pirmp_pkg for operation codes, cfg_t and stage1_t.
`timescale 1ns / 1ps

module pirmp_state (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pirmp_pkg::cfg_t                   cfg,
    input  logic                              step_valid,
    output logic                              step_stall,
    input  logic                              operation,
    input  logic signed [pirmp_pkg::DATA_W-1:0] setpoint,
    input  logic signed [pirmp_pkg::DATA_W-1:0] process_value,
    output logic                              s1_valid,
    input  logic                              s1_ready,
    output pirmp_pkg::stage1_t                s1_data
);
    import pirmp_pkg::*;

    localparam int WIDE_W = DATA_W + 2;

    // Input register.
    logic                     v0_reg;
    logic                     op0_reg;
    logic signed [DATA_W-1:0] sp0_reg;
    logic signed [DATA_W-1:0] pv0_reg;

    // Loop state.
    logic signed [DATA_W-1:0] ramp_reg;
    logic signed [DATA_W-1:0] ramp_next;
    logic signed [DATA_W-1:0] integ_reg;
    logic signed [DATA_W-1:0] integ_next;

    // Output register of this stage.
    logic    v1_reg;
    stage1_t s1_reg;
    stage1_t s1_next;

    logic s1_free;
    logic s0_fire;
    logic step_take;

    logic signed [WIDE_W-1:0] cur_x;
    logic signed [WIDE_W-1:0] sp_x;
    logic signed [WIDE_W-1:0] pv_x;
    logic signed [WIDE_W-1:0] accel_x;
    logic signed [WIDE_W-1:0] up_x;
    logic signed [WIDE_W-1:0] dn_x;
    logic signed [DATA_W-1:0] step_tgt;
    logic signed [WIDE_W-1:0] isum_x;
    logic signed [DATA_W-1:0] isum_sat;
    logic                     integ_open;

    // Handshake: the input register empties whenever the next slot is free.
    assign s1_free    = !v1_reg || s1_ready;
    assign s0_fire    = v0_reg && s1_free;
    assign step_stall = v0_reg && !s1_free;
    assign step_take  = step_valid && !step_stall;
    assign s1_valid   = v1_reg;
    assign s1_data    = s1_reg;

    // Ramp the target toward the setpoint by at most the acceleration limit; a zero limit jumps straight to it.
    always_comb
    begin
        cur_x   = WIDE_W'(ramp_reg);
        sp_x    = WIDE_W'(sp0_reg);
        pv_x    = WIDE_W'(pv0_reg);
        accel_x = $signed({{(WIDE_W-ACCEL_W){1'b0}}, cfg.accel_limit});
        up_x    = cur_x + accel_x;
        dn_x    = cur_x - accel_x;
        step_tgt = sp0_reg;
        if (cfg.accel_limit != '0 && ramp_reg != sp0_reg)
        begin
            if (ramp_reg < sp0_reg)
            begin
                step_tgt = (up_x > sp_x) ? sp0_reg : up_x[DATA_W-1:0];
            end
            else
            begin
                step_tgt = (dn_x < sp_x) ? sp0_reg : dn_x[DATA_W-1:0];
            end
        end
    end

    // Integral update, gated by the output limits and saturated to 32 bits.
    always_comb
    begin
        integ_open = (integ_reg > cfg.out_min) && (integ_reg < cfg.out_max);
        isum_x     = WIDE_W'(integ_reg) + (WIDE_W'(step_tgt) - pv_x);
        if (isum_x[WIDE_W-1] != isum_x[DATA_W-1] || isum_x[WIDE_W-2] != isum_x[DATA_W-1])
        begin
            isum_sat = isum_x[WIDE_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                        : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            isum_sat = isum_x[DATA_W-1:0];
        end
    end

    // Next state and stage payload.
    always_comb
    begin
        ramp_next     = ramp_reg;
        integ_next    = integ_reg;
        s1_next.err   = ERR_W'(ramp_reg) - ERR_W'(pv0_reg);
        s1_next.integ = integ_open ? isum_sat : integ_reg;
        if (s0_fire)
        begin
            case (op_t'(op0_reg))
                OP_INIT:
                begin
                    ramp_next  = sp0_reg;
                    integ_next = '0;
                end
                OP_STEP:
                begin
                    ramp_next  = step_tgt;
                    integ_next = s1_next.integ;
                end
                default:
                begin
                    ramp_next  = ramp_reg;
                    integ_next = integ_reg;
                end
            endcase
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            ramp_reg  <= '0;
            integ_reg <= '0;
        end
        else
        begin
            if (!v0_reg || s1_free)
            begin
                v0_reg <= step_valid;
            end
            if (s1_free)
            begin
                v1_reg <= s0_fire && (op_t'(op0_reg) == OP_STEP);
            end
            ramp_reg  <= ramp_next;
            integ_reg <= integ_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (step_take)
        begin
            op0_reg <= operation;
            sp0_reg <= setpoint;
            pv0_reg <= process_value;
        end
        if (s0_fire)
        begin
            s1_reg <= s1_next;
        end
    end

endmodule

[rtl/core/pirmp_mult.sv]
// Multiplier stage: proportional and integral products, one register stage.
// Depends on pirmp_pkg for cfg_t, stage1_t and stage2_t.
`timescale 1ns / 1ps

module pirmp_mult (
    input  logic               clk,
    input  logic               rst_n,
    input  pirmp_pkg::cfg_t    cfg,
    input  logic               s1_valid,
    output logic               s1_ready,
    input  pirmp_pkg::stage1_t s1_data,
    output logic               s2_valid,
    input  logic               s2_ready,
    output pirmp_pkg::stage2_t s2_data
);
    import pirmp_pkg::*;

    logic    v2_reg;
    stage2_t s2_reg;
    stage2_t s2_next;
    logic    s2_free;

    assign s2_free  = !v2_reg || s2_ready;
    assign s1_ready = s2_free;
    assign s2_valid = v2_reg;
    assign s2_data  = s2_reg;

    // Full-width signed products.
    always_comb
    begin
        s2_next.prod_p = PRODP_W'(cfg.p_gain) * PRODP_W'(s1_data.err);
        s2_next.prod_i = PRODI_W'(cfg.i_gain) * PRODI_W'(s1_data.integ);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            v2_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid && s2_free)
        begin
            s2_reg <= s2_next;
        end
    end

endmodule

[rtl/core/pirmp_out.sv]
// Output stage: scale products, sum, clamp to limits, result register.
// Depends on pirmp_pkg for cfg_t and stage2_t.
`timescale 1ns / 1ps

module pirmp_out #(
    parameter int FRAC_BITS = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pirmp_pkg::cfg_t                     cfg,
    input  logic                                s2_valid,
    output logic                                s2_ready,
    input  pirmp_pkg::stage2_t                  s2_data,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [pirmp_pkg::DATA_W-1:0] control_out
);
    import pirmp_pkg::*;

    localparam int SUM_W = PRODP_W + 1;

    logic                     result_valid_reg;
    logic signed [DATA_W-1:0] out_reg;
    logic signed [DATA_W-1:0] out_next;
    logic signed [SUM_W-1:0]  sum_x;
    logic                     out_free;

    assign out_free     = !result_valid_reg || !result_stall;
    assign s2_ready     = out_free;
    assign result_valid = result_valid_reg;
    assign control_out  = out_reg;

    // Arithmetic shifts round toward minus infinity; low limit checked first.
    always_comb
    begin
        sum_x = SUM_W'(s2_data.prod_p >>> FRAC_BITS)
              + SUM_W'(s2_data.prod_i >>> FRAC_BITS);
        if (sum_x < SUM_W'(cfg.out_min))
        begin
            out_next = cfg.out_min;
        end
        else if (sum_x > SUM_W'(cfg.out_max))
        begin
            out_next = cfg.out_max;
        end
        else
        begin
            out_next = sum_x[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            result_valid_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid && out_free)
        begin
            out_reg <= out_next;
        end
    end

endmodule

[rtl/core/pi_controller_setpoint_ramp_core.sv]
// PI controller with setpoint ramp, top level.
// A step item passes through the input, state, product and result registers in turn.
// Throughput: one item per cycle while result_stall does not hold the pipeline; the loop state
// (ramped target and integral) is updated as an item leaves the input register.
// Init items give no result. Reset clears the loop state and all valid flags
// and loads the configuration defaults (gains 0, limits +/-900 scaled).
// Depends on pirmp_pkg and the pirmp_* submodules.
`timescale 1ns / 1ps

module pi_controller_setpoint_ramp_core #(
    parameter int FRAC_BITS = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pirmp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pirmp_pkg::DATA_W-1:0]        cfg_data,
    input  logic                                step_valid,
    output logic                                step_stall,
    input  logic                                operation,
    input  logic signed [pirmp_pkg::DATA_W-1:0] setpoint,
    input  logic signed [pirmp_pkg::DATA_W-1:0] process_value,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [pirmp_pkg::DATA_W-1:0] control_out
);
    import pirmp_pkg::*;

    cfg_t    cfg;
    logic    s1_valid;
    logic    s1_ready;
    stage1_t s1_data;
    logic    s2_valid;
    logic    s2_ready;
    stage2_t s2_data;

    // Configuration registers.
    pirmp_cfg_regs #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register and state update.
    pirmp_state u_state (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .step_valid    (step_valid),
        .step_stall    (step_stall),
        .operation     (operation),
        .setpoint      (setpoint),
        .process_value (process_value),
        .s1_valid      (s1_valid),
        .s1_ready      (s1_ready),
        .s1_data       (s1_data)
    );

    // Gain products.
    pirmp_mult u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1_data  (s1_data),
        .s2_valid (s2_valid),
        .s2_ready (s2_ready),
        .s2_data  (s2_data)
    );

    // Sum, clamp and result register.
    pirmp_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .s2_valid     (s2_valid),
        .s2_ready     (s2_ready),
        .s2_data      (s2_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .control_out  (control_out)
    );

endmodule

[sim/tb.sv]
// Self-checking testbench for pi_controller_setpoint_ramp_core: a local PI loop predictor
// with setpoint ramp checks every result under random idle and stall. Needs pirmp_pkg and the
// core RTL.
`timescale 1ns / 1ps

module tb;
    import pirmp_pkg::*;

    localparam int FRAC = 5;
    localparam int SETTLE_CYCLES = 10;
    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;
    localparam int CFG_NUM_REGS = 5;
    localparam int RAND_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int SEND_MIX[RAND_PHASES] = '{0, 20, 60, 0, 40, 10};
    localparam int RECV_MIX[RAND_PHASES] = '{0, 50, 10, 70, 0, 30};
    localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [ACCEL_W-1:0] ACCEL_MAX = {ACCEL_W{1'b1}};
    localparam logic signed [DATA_W-1:0] ONE_FP = 1 << FRAC;
    localparam logic signed [DATA_W-1:0] LIMIT_FP = FULL_SCALE << FRAC;

    typedef struct {
        op_t                      op;
        logic signed [DATA_W-1:0] sp;
        logic signed [DATA_W-1:0] pv;
    } step_item_t;

    // Clock, reset and every block input start at known values.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;
    logic step_valid = 1'b0;
    logic operation = OP_STEP;
    logic signed [DATA_W-1:0] setpoint = '0;
    logic signed [DATA_W-1:0] process_value = '0;
    logic result_stall = 1'b0;
    logic cfg_ready;
    logic step_stall;
    logic result_valid;
    logic signed [DATA_W-1:0] control_out;

    // Handshake flags seen at the last rising edge, used by the falling-edge drivers.
    logic step_took = 1'b0;
    logic result_took = 1'b0;

    step_item_t step_queue[$];
    logic signed [DATA_W-1:0] ctrl_expected[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int send_gap = 0;
    int recv_hold = 0;
    int error_count = 0;
    int idle_cycles = 0;

    // Predictor copy of the configuration and the loop state, at reset values.
    logic signed [DATA_W-1:0] mdl_kp = '0;
    logic signed [DATA_W-1:0] mdl_ki = '0;
    logic signed [DATA_W-1:0] mdl_lo = -LIMIT_FP;
    logic signed [DATA_W-1:0] mdl_hi = LIMIT_FP;
    logic [ACCEL_W-1:0] mdl_accel = '0;
    logic signed [DATA_W-1:0] mdl_ramp = '0;
    logic signed [DATA_W-1:0] mdl_integ = '0;

    pi_controller_setpoint_ramp_core #(
        .FRAC_BITS(FRAC)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .step_valid(step_valid),
        .step_stall(step_stall),
        .operation(operation),
        .setpoint(setpoint),
        .process_value(process_value),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .control_out(control_out)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int draw_gap(input int pct);
        return ($urandom_range(0, 99) < pct) ? $urandom_range(1, 16) : 0;
    endfunction

    // Advances the loop state by one step item and returns the clamped output.
    function automatic logic signed [DATA_W-1:0] ctrl_update(input longint sp, input longint pv);
        longint cur;
        longint nxt;
        longint acc;
        longint err;
        longint sum;
        cur = longint'(mdl_ramp);
        acc = longint'(mdl_accel);
        nxt = sp;
        if (acc > 0 && cur != sp)
        begin
            if (cur < sp)
                nxt = (cur + acc > sp) ? sp : cur + acc;
            else
                nxt = (cur - acc < sp) ? sp : cur - acc;
        end
        mdl_ramp = nxt[DATA_W-1:0];
        err = cur - pv;
        // The integral only moves while it sits strictly inside the output limits.
        if (mdl_integ > mdl_lo && mdl_integ < mdl_hi)
        begin
            sum = longint'(mdl_integ) + (nxt - pv);
            if (sum > longint'(S32_MAX))
                sum = longint'(S32_MAX);
            else if (sum < longint'(S32_MIN))
                sum = longint'(S32_MIN);
            mdl_integ = sum[DATA_W-1:0];
        end
        sum = ((longint'(mdl_kp) * err) >>> FRAC)
            + ((longint'(mdl_ki) * longint'(mdl_integ)) >>> FRAC);
        // Low limit is checked first, so crossed limits favor out_min.
        if (sum < longint'(mdl_lo))
            sum = longint'(mdl_lo);
        else if (sum > longint'(mdl_hi))
            sum = longint'(mdl_hi);
        return sum[DATA_W-1:0];
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("check failed at %0t: %s", $realtime, msg);
    endtask

    // Monitor: tracks handshakes, updates the predictor and checks results.
    always @(posedge clk)
    begin
        logic step_fire;
        logic res_fire;
        logic cfg_fire;
        logic signed [DATA_W-1:0] want;
        if (rst_n)
        begin
            step_fire = step_valid && !step_stall;
            res_fire = result_valid && !result_stall;
            cfg_fire = cfg_valid && cfg_ready;
            step_took <= step_fire;
            result_took <= res_fire;

            if (cfg_fire)
            begin
                case (cfg_index)
                    CFG_P_GAIN:      mdl_kp = cfg_data;
                    CFG_I_GAIN:      mdl_ki = cfg_data;
                    CFG_OUT_MIN:     mdl_lo = cfg_data;
                    CFG_OUT_MAX:     mdl_hi = cfg_data;
                    CFG_ACCEL_LIMIT: mdl_accel = cfg_data[ACCEL_W-1:0];
                    default:         ;
                endcase
            end

            if (step_fire)
            begin
                if (op_t'(operation) == OP_INIT)
                begin
                    mdl_ramp = setpoint;
                    mdl_integ = '0;
                end
                else
                    ctrl_expected.push_back(ctrl_update(longint'(setpoint),
                                                        longint'(process_value)));
            end

            if (res_fire)
            begin
                if (ctrl_expected.size() == 0)
                    note_failure($sformatf("result %0d with nothing expected", control_out));
                else
                begin
                    want = ctrl_expected.pop_front();
                    if (control_out !== want)
                        note_failure($sformatf("control_out expected %0d got %0d",
                                               want, control_out));
                end
            end

            // Watchdog on cycles with no accepted transfer on any channel.
            if (step_fire || res_fire || cfg_fire)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog expired with %0d results outstanding",
                         ctrl_expected.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Item driver: holds a stalled item, otherwise idles or presents the next queued item.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (step_valid && step_took)
            begin
                void'(step_queue.pop_front());
                send_gap = draw_gap(send_idle_pct);
            end
            if (!(step_valid && !step_took))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    step_valid <= 1'b0;
                end
                else if (step_queue.size() > 0)
                begin
                    step_valid <= 1'b1;
                    operation <= step_queue[0].op;
                    setpoint <= step_queue[0].sp;
                    process_value <= step_queue[0].pv;
                end
                else
                    step_valid <= 1'b0;
            end
        end
    end

    // Result receiver: may stall for a random count after each accepted result.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_took)
                recv_hold = draw_gap(recv_idle_pct);
            if (recv_hold > 0)
            begin
                recv_hold--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic cfg_release();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_item(input op_t op, input logic signed [DATA_W-1:0] sp,
                              input logic signed [DATA_W-1:0] pv);
        step_item_t it;
        it.op = op;
        it.sp = sp;
        it.pv = pv;
        step_queue.push_back(it);
    endtask

    // Waits until every item is sent and every result is back, then lets the pipe drain.
    task automatic wait_idle();
        while (step_queue.size() != 0 || ctrl_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly small values so the ramp and integral stay in play, now and then full range.
    function automatic logic signed [DATA_W-1:0] rand_level();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1, 2:    return $urandom_range(0, 1 << 21) - (1 << 20);
            default: return $urandom_range(0, 6000) - 3000;
        endcase
    endfunction

    task automatic write_random_config();
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        case ($urandom_range(0, 3))
            0:       cfg_write(CFG_P_GAIN, $urandom);
            default: cfg_write(CFG_P_GAIN, $urandom_range(0, 16 * ONE_FP) - 8 * ONE_FP);
        endcase
        case ($urandom_range(0, 3))
            0:       cfg_write(CFG_I_GAIN, $urandom);
            default: cfg_write(CFG_I_GAIN, $urandom_range(0, 2 * ONE_FP) - ONE_FP);
        endcase
        a = $urandom;
        b = $urandom;
        case ($urandom_range(0, 3))
            0:
            begin
                cfg_write(CFG_OUT_MIN, -LIMIT_FP);
                cfg_write(CFG_OUT_MAX, LIMIT_FP);
            end
            1:
            begin
                cfg_write(CFG_OUT_MIN, ($signed(a) < $signed(b)) ? a : b);
                cfg_write(CFG_OUT_MAX, ($signed(a) < $signed(b)) ? b : a);
            end
            2:
            begin
                cfg_write(CFG_OUT_MIN, S32_MIN);
                cfg_write(CFG_OUT_MAX, S32_MAX);
            end
            default:
            begin
                cfg_write(CFG_OUT_MIN, a);
                cfg_write(CFG_OUT_MAX, b);
            end
        endcase
        case ($urandom_range(0, 3))
            0:       cfg_write(CFG_ACCEL_LIMIT, '0);
            1:       cfg_write(CFG_ACCEL_LIMIT, $urandom_range(1, 500));
            2:       cfg_write(CFG_ACCEL_LIMIT, $urandom);
            default: cfg_write(CFG_ACCEL_LIMIT, DATA_W'(ACCEL_MAX));
        endcase
        // Writes to unused indexes must leave every register alone.
        if ($urandom_range(0, 2) == 0)
            cfg_write(CFG_IDX_W'($urandom_range(CFG_NUM_REGS, (1 << CFG_IDX_W) - 1)),
                      $urandom);
        cfg_release();
    endtask

    task automatic queue_random_items(input int count);
        int kind;
        logic signed [DATA_W-1:0] sp;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 19);
            sp = rand_level();
            if (kind == 0)
                queue_item(OP_INIT, sp, $urandom);
            else if (kind < 3)
                queue_item(OP_STEP, $urandom, $urandom);
            else
                queue_item(OP_STEP, sp, sp - ($urandom_range(0, 400) - 200));
        end
    endtask

    // Stimulus: directed phases first, then randomized configurations and items.
    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset limits and no ramping; unity proportional gain and a tiny integral gain.
        cfg_write(CFG_P_GAIN, ONE_FP);
        cfg_write(CFG_I_GAIN, 1);
        cfg_release();
        queue_item(OP_STEP, 0, 0);
        queue_item(OP_STEP, 1000, 0);
        queue_item(OP_STEP, 1000, 1000);
        queue_item(OP_STEP, 0, S32_MIN);
        queue_item(OP_STEP, 0, S32_MAX);
        queue_item(OP_INIT, 500, $urandom);
        queue_item(OP_STEP, 500, 400);
        wait_idle();

        // Extreme gains, full-range limits, slow ramp and integral saturation both ways.
        cfg_write(CFG_P_GAIN, S32_MIN);
        cfg_write(CFG_I_GAIN, S32_MAX);
        cfg_write(CFG_OUT_MIN, S32_MIN);
        cfg_write(CFG_OUT_MAX, S32_MAX);
        cfg_write(CFG_ACCEL_LIMIT, 100);
        cfg_write(CFG_IDX_W'((1 << CFG_IDX_W) - 1), $urandom);
        cfg_release();
        queue_item(OP_INIT, 0, 0);
        queue_item(OP_STEP, 1000, 0);
        queue_item(OP_STEP, 1000, 0);
        queue_item(OP_STEP, -1000, 0);
        queue_item(OP_STEP, S32_MAX, S32_MIN);
        queue_item(OP_STEP, S32_MAX, S32_MIN);
        queue_item(OP_INIT, S32_MIN, 0);
        queue_item(OP_STEP, S32_MIN, S32_MAX);
        wait_idle();

        // Crossed limits with the largest ramp step, which must stop at the setpoint.
        cfg_write(CFG_P_GAIN, ONE_FP);
        cfg_write(CFG_I_GAIN, -ONE_FP);
        cfg_write(CFG_OUT_MIN, 1000);
        cfg_write(CFG_OUT_MAX, -1000);
        cfg_write(CFG_ACCEL_LIMIT, DATA_W'(ACCEL_MAX));
        cfg_release();
        queue_item(OP_INIT, S32_MIN, 0);
        queue_item(OP_STEP, S32_MAX, 0);
        queue_item(OP_STEP, S32_MAX, 0);
        queue_item(OP_STEP, S32_MIN, 0);
        queue_item(OP_STEP, 0, 5000);
        queue_item(OP_STEP, 0, -5000);
        wait_idle();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            write_random_config();
            send_idle_pct = SEND_MIX[ph];
            recv_idle_pct = RECV_MIX[ph];
            queue_random_items(ITEMS_PER_PHASE);
            wait_idle();
        end

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
